@@ hdl/rmss_pkg.sv @@
// ----------------------------------------------------------------------------
// rmss_pkg: receiver mute/stop supervisor package
// Holds the transaction payload types, the state and configuration types, and
// the register indexes and reset values.
// ----------------------------------------------------------------------------
package rmss_pkg;

    localparam int unsigned CountW = 8;
    localparam int unsigned IndexW = 2;

    typedef logic [CountW-1:0] count_t;
    typedef logic [IndexW-1:0] cfg_index_t;

    localparam count_t     CFG_RESET_VALUE = count_t'(16);
    localparam cfg_index_t IDX_STOP_TICKS  = cfg_index_t'(0);
    localparam cfg_index_t IDX_RUN_ALLOW   = cfg_index_t'(1);
    localparam cfg_index_t IDX_HOLD_TICKS  = cfg_index_t'(2);

    typedef struct packed {
        logic silence;
        logic confidence_error;
        logic pcm;
    } rmss_in_t;

    typedef struct packed {
        logic mute_req;
        logic unmute_req;
        logic stop_req;
        logic run_req;
        logic fault_led;
        logic error_flash;
    } rmss_out_t;

    typedef struct packed {
        count_t stop_ticks;
        count_t run_allowance;
        count_t error_hold_ticks;
    } rmss_cfg_t;

    typedef struct packed {
        count_t stop_count;
        count_t allowance_left;
        count_t hold_left;
        logic   fault_led_level;
    } rmss_state_t;

endpackage

@@ hdl/rmss_step.sv @@
// ----------------------------------------------------------------------------
// rmss_step: one tick of the supervisor
// Combinational update of the supervisor state and the tick's requests from
// one status sample.
// ----------------------------------------------------------------------------
module rmss_step (
    input  rmss_pkg::rmss_cfg_t   cfg,
    input  rmss_pkg::rmss_state_t state,
    input  rmss_pkg::rmss_in_t    item,
    output rmss_pkg::rmss_state_t state_next,
    output rmss_pkg::rmss_out_t   result
);
    import rmss_pkg::*;

    count_t stop_load;
    count_t stop_dec;
    logic   allow_spent;

    assign stop_load   = (cfg.stop_ticks == '0) ? count_t'(1) : cfg.stop_ticks;
    assign stop_dec    = state.stop_count - count_t'(1);
    assign allow_spent = (state.allowance_left == '0);

    always_comb
    begin
        state_next = state;
        result     = '0;
        priority if (state.stop_count != '0)
        begin
            state_next.stop_count = stop_dec;
            if (stop_dec == '0)
            begin
                result.run_req            = 1'b1;
                state_next.allowance_left = cfg.run_allowance;
            end
        end
        else if (item.silence)
        begin
            result.mute_req            = 1'b1;
            state_next.fault_led_level = 1'b1;
        end
        else if (item.confidence_error || !item.pcm)
        begin
            result.mute_req = 1'b1;
            if (allow_spent)
            begin
                state_next.stop_count = stop_load;
                result.stop_req       = 1'b1;
            end
            else
            begin
                state_next.allowance_left = state.allowance_left - count_t'(1);
            end
            if (item.confidence_error)
            begin
                state_next.hold_left = cfg.error_hold_ticks;
                result.error_flash   = 1'b1;
            end
            else
            begin
                state_next.fault_led_level = 1'b1;
            end
        end
        else if (state.hold_left == '0)
        begin
            result.unmute_req          = 1'b1;
            state_next.fault_led_level = 1'b0;
        end
        else
        begin
            state_next.hold_left = state.hold_left - count_t'(1);
        end
        result.fault_led = state_next.fault_led_level;
    end

endmodule

@@ hdl/receiver_mute_stop_supervisor.sv @@
// ----------------------------------------------------------------------------
// receiver_mute_stop_supervisor: audio receiver mute/stop supervisor
// An input transaction goes through the input register, then the result
// register. Throughput: one transaction per cycle while out_stall does not hold
// the output, set by the single state update in the step logic. After reset:
// running, counters zero, LED unlit, all three configuration registers 16.
// ----------------------------------------------------------------------------
module receiver_mute_stop_supervisor (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  rmss_pkg::rmss_in_t     in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output rmss_pkg::rmss_out_t    out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  rmss_pkg::cfg_index_t   cfg_index,
    input  rmss_pkg::count_t       cfg_data
);
    import rmss_pkg::*;

    rmss_cfg_t   cfg_reg;
    rmss_cfg_t   cfg_next;
    rmss_state_t state_reg;
    rmss_state_t state_next;
    rmss_in_t    in_data_reg;
    rmss_out_t   out_data_reg;
    rmss_out_t   result;
    logic        in_valid_reg;
    logic        out_valid_reg;
    logic        out_free;
    logic        advance;
    logic        in_load;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_load   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                IDX_STOP_TICKS: cfg_next.stop_ticks       = cfg_data;
                IDX_RUN_ALLOW:  cfg_next.run_allowance    = cfg_data;
                IDX_HOLD_TICKS: cfg_next.error_hold_ticks = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    rmss_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (in_data_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '{CFG_RESET_VALUE, CFG_RESET_VALUE, CFG_RESET_VALUE};
            state_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (in_load || advance)
            begin
                in_valid_reg <= in_load;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    // stop and run are never requested on the same tick
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.stop_req && out_data_reg.run_req))
        else $error("stop and run requested together");

    // while stopped only a run request can come out
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && state_reg.stop_count != '0) |=>
            !(out_data_reg.mute_req || out_data_reg.unmute_req ||
              out_data_reg.stop_req || out_data_reg.error_flash))
        else $error("request issued while receiver stopped");

    // a stop request always starts a nonzero countdown
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result.stop_req) |=> (state_reg.stop_count != '0))
        else $error("stop without countdown");

    // a run request leaves the receiver running
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result.run_req) |=> (state_reg.stop_count == '0))
        else $error("run request while countdown still pending");

    // state moves only with a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without a transaction");

endmodule
